FILE: rtl/rmst_pkg.sv
// Shared types and constants for the range-maximum segment tree.
// Used by rmst_ctrl, rmst_dp and range_max_segment_tree; depends on nothing.
`default_nettype none

package rmst_pkg;

  // Field and register widths
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 10;
  localparam int LEN_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_VALUE   = 1'd1;

  // Register reset values
  localparam logic [LEN_W-1:0]          ACTIVE_LENGTH_RST = 11'd1024;
  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE_RST   = -32'sd1;

  // Most negative value: content of every unwritten node
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;     // write one node of the clearing pass
    logic accept;    // item transfer this cycle
    logic w_read;    // read sibling of current node
    logic w_update;  // write parent maximum, climb one level
    logic q_low;     // low-bound step of a query level
    logic q_high;    // high-bound step and level shift of a query
    logic q_done;    // capture the accumulator as result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;   // clearing pass at its last node
    logic write_ok;     // write position inside the active length
    logic parent_root;  // parent of current node is the root
    logic q_end;        // query bounds have met
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/range_max_segment_tree.sv
// Top level of the range-maximum segment tree: controller plus datapath.
// Depends on rmst_pkg, rmst_ctrl, rmst_dp (which holds rmst_ram).
//
//   Channel  Ports                                         Transfer
//   input    start, busy, in_kind, in_position,            start && !busy
//            in_new_value, in_range_first, in_range_last
//   result   out_valid, out_range_maximum                  out_valid (one cycle)
//   config   cfg_we, cfg_index, cfg_data                   cfg_we
//
// After reset the block sweeps all 2*LEAF_COUNT nodes to the most negative
// value, holding busy high throughout; config writes still land.
// A write item climbs log2(LEAF_COUNT) levels, each a sibling read then a
// parent write in the node memory. An out-of-range write is taken but
// stores nothing and starts no climb.
// A query takes the transfer, up to log2(LEAF_COUNT)+1 levels of a low-bound
// and a high-bound step, a final bound check and the result capture;
// out_valid rises in the cycle busy falls.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module range_max_segment_tree #(
  parameter int LEAF_COUNT = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_kind,
  input  wire logic [rmst_pkg::POS_W-1:0]           in_position,
  input  wire logic signed [rmst_pkg::VALUE_W-1:0]  in_new_value,
  input  wire logic [rmst_pkg::POS_W-1:0]           in_range_first,
  input  wire logic [rmst_pkg::POS_W-1:0]           in_range_last,
  output logic                                      out_valid,
  output logic signed [rmst_pkg::VALUE_W-1:0]       out_range_maximum,
  input  wire logic                                 cfg_we,
  input  wire logic [rmst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rmst_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rmst_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  rmst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Node memory and arithmetic
  rmst_dp #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_kind           (in_kind),
    .in_position       (in_position),
    .in_new_value      (in_new_value),
    .in_range_first    (in_range_first),
    .in_range_last     (in_range_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_range_maximum (out_range_maximum)
  );

endmodule

`default_nettype wire

FILE: rtl/rmst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rmst_ctrl.sv
// Sequencer for the segment tree: clearing pass, write climb, query walk.
// Depends on rmst_pkg for the command and status structs.
`default_nettype none

module rmst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_kind,
  input  wire rmst_pkg::dp_sts_t sts_i,
  output rmst_pkg::dp_cmd_t      cmd_o,
  output logic                   busy_o
);
  import rmst_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_W_READ   = 7'b0000100,
    S_W_UPDATE = 7'b0001000,
    S_Q_LOW    = 7'b0010000,
    S_Q_HIGH   = 7'b0100000,
    S_Q_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts_i.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_kind == KIND_QUERY) state_nxt = S_Q_LOW;
          else if (sts_i.write_ok)   state_nxt = S_W_READ;
        end
      end
      S_W_READ:   state_nxt = S_W_UPDATE;
      S_W_UPDATE: state_nxt = sts_i.parent_root ? S_IDLE : S_W_READ;
      S_Q_LOW:    state_nxt = sts_i.q_end ? S_Q_DONE : S_Q_HIGH;
      S_Q_HIGH:   state_nxt = S_Q_LOW;
      S_Q_DONE:   state_nxt = S_IDLE;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode commands
  always_comb begin
    cmd_o.clear    = (state_r == S_CLEAR);
    cmd_o.accept   = (state_r == S_IDLE) && start;
    cmd_o.w_read   = (state_r == S_W_READ);
    cmd_o.w_update = (state_r == S_W_UPDATE);
    cmd_o.q_low    = (state_r == S_Q_LOW) && !sts_i.q_end;
    cmd_o.q_high   = (state_r == S_Q_HIGH);
    cmd_o.q_done   = (state_r == S_Q_DONE);
  end

  assign busy_o = (state_r != S_IDLE);

  // Result capture only after the query walk ends
  a_done_after_low: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_DONE) |-> $past(state_r == S_Q_LOW))
    else $error("query result captured without a finished walk");

  // Each parent update uses a sibling read from the previous cycle
  a_update_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.w_update |-> $past(cmd_o.w_read))
    else $error("parent update without sibling read");

endmodule

`default_nettype wire

FILE: rtl/rmst_dp.sv
// Datapath of the segment tree: config registers, node memory, index and
// accumulator registers. Depends on rmst_pkg and rmst_ram.
`default_nettype none

module rmst_dp #(
  parameter int LEAF_COUNT = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire rmst_pkg::dp_cmd_t                    cmd_i,
  output rmst_pkg::dp_sts_t                         sts_o,
  input  wire logic                                 in_kind,
  input  wire logic [rmst_pkg::POS_W-1:0]           in_position,
  input  wire logic signed [rmst_pkg::VALUE_W-1:0]  in_new_value,
  input  wire logic [rmst_pkg::POS_W-1:0]           in_range_first,
  input  wire logic [rmst_pkg::POS_W-1:0]           in_range_last,
  input  wire logic                                 cfg_we,
  input  wire logic [rmst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rmst_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                      out_valid,
  output logic signed [rmst_pkg::VALUE_W-1:0]       out_range_maximum
);
  import rmst_pkg::*;

  localparam int NODE_COUNT = 2 * LEAF_COUNT;
  localparam int NW = $clog2(NODE_COUNT);       // node address width
  localparam int HW = NW + 1;                   // bound width, holds NODE_COUNT
  localparam int CW = (HW > LEN_W) ? HW : LEN_W; // compare width

  logic [LEN_W-1:0]          active_length_r;
  logic signed [VALUE_W-1:0] empty_value_r;
  logic [NW-1:0]             clr_addr_r;
  logic [NW-1:0]             k_r;
  logic signed [VALUE_W-1:0] cur_r;
  logic [HW-1:0]             lo_r;
  logic [HW-1:0]             hi_r;
  logic signed [VALUE_W-1:0] acc_r;
  logic                      pend_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;

  logic [CW-1:0]             leaf_cnt_c;
  logic [CW-1:0]             len_c;
  logic [CW-1:0]             pos_c;
  logic [CW-1:0]             first_c;
  logic [CW-1:0]             last_c;
  logic [CW-1:0]             last_clip_c;
  logic                      write_ok_c;
  logic                      q_empty_c;
  logic [HW-1:0]             lo_start_c;
  logic [HW-1:0]             hi_start_c;
  logic [NW-1:0]             leaf_addr_c;
  logic [NW-1:0]             parent_c;
  logic signed [VALUE_W-1:0] upd_max_c;

  logic                      ram_we;
  logic [NW-1:0]             ram_waddr;
  logic signed [VALUE_W-1:0] ram_wdata;
  logic                      ram_re;
  logic [NW-1:0]             ram_raddr;
  logic signed [VALUE_W-1:0] ram_rdata;

  // Effective length, write range check and query clipping
  always_comb begin
    leaf_cnt_c  = CW'(LEAF_COUNT);
    len_c       = (CW'(active_length_r) > leaf_cnt_c) ? leaf_cnt_c : CW'(active_length_r);
    pos_c       = CW'(in_position);
    first_c     = CW'(in_range_first);
    last_c      = CW'(in_range_last);
    last_clip_c = (last_c >= len_c) ? (len_c - CW'(1)) : last_c;
    write_ok_c  = (pos_c < len_c);
    q_empty_c   = (len_c == '0) || (first_c > last_clip_c);
    lo_start_c  = HW'(first_c + leaf_cnt_c);
    hi_start_c  = HW'(last_clip_c + leaf_cnt_c + CW'(1));
    leaf_addr_c = NW'(pos_c + leaf_cnt_c);
  end

  // Write climb: parent index and new parent maximum
  assign parent_c  = {1'b0, k_r[NW-1:1]};
  assign upd_max_c = (cur_r > ram_rdata) ? cur_r : ram_rdata;

  // Status to the controller
  always_comb begin
    sts_o.clear_last  = (clr_addr_r == NW'(NODE_COUNT - 1));
    sts_o.write_ok    = write_ok_c;
    sts_o.parent_root = (k_r[NW-1:1] == (NW-1)'(1));
    sts_o.q_end       = !(lo_r < hi_r);
  end

  // Node memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = VALUE_MIN;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd_i.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
    end
    if (cmd_i.accept && (in_kind == KIND_WRITE) && write_ok_c) begin
      ram_we    = 1'b1;
      ram_waddr = leaf_addr_c;
      ram_wdata = in_new_value;
    end
    if (cmd_i.w_read) begin
      ram_re    = 1'b1;
      ram_raddr = {k_r[NW-1:1], ~k_r[0]};
    end
    if (cmd_i.w_update) begin
      ram_we    = 1'b1;
      ram_waddr = parent_c;
      ram_wdata = upd_max_c;
    end
    if (cmd_i.q_low && lo_r[0]) begin
      ram_re    = 1'b1;
      ram_raddr = lo_r[NW-1:0];
    end
    if (cmd_i.q_high && hi_r[0]) begin
      ram_re    = 1'b1;
      ram_raddr = {hi_r[NW-1:1], 1'b0};
    end
  end

  rmst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_length_r <= ACTIVE_LENGTH_RST;
      empty_value_r   <= EMPTY_VALUE_RST;
    end else if (cfg_we) begin
      priority if (cfg_index == REG_ACTIVE_LENGTH) begin
        active_length_r <= cfg_data[LEN_W-1:0];
      end else if (cfg_index == REG_EMPTY_VALUE) begin
        empty_value_r <= cfg_data[VALUE_W-1:0];
      end
    end
  end

  // Control: clearing counter, pending query read, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_addr_r <= clr_addr_r + NW'(1);
      pend_r      <= ram_re && (cmd_i.q_low || cmd_i.q_high);
      out_valid_r <= cmd_i.q_done;
    end
  end

  // Payload: node index, climbing value, query bounds, accumulator
  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      k_r   <= leaf_addr_c;
      cur_r <= in_new_value;
      lo_r  <= q_empty_c ? '0 : lo_start_c;
      hi_r  <= q_empty_c ? '0 : hi_start_c;
      acc_r <= q_empty_c ? empty_value_r : VALUE_MIN;
    end else begin
      if (cmd_i.w_update) begin
        k_r   <= parent_c;
        cur_r <= upd_max_c;
      end
      if (cmd_i.q_low && lo_r[0]) lo_r <= lo_r + HW'(1);
      if (cmd_i.q_high) begin
        lo_r <= lo_r >> 1;
        hi_r <= hi_r >> 1;
      end
      // fold in the node read in the previous cycle
      if (pend_r && (ram_rdata > acc_r)) acc_r <= ram_rdata;
    end
    if (cmd_i.q_done) out_value_r <= acc_r;
  end

  assign out_valid         = out_valid_r;
  assign out_range_maximum = out_value_r;

  // No read of a node in the cycle it is written
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("node read and written in the same cycle");

  // Climb never goes above the root
  a_climb_below_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.w_update |-> (k_r[NW-1:1] != '0))
    else $error("write climb past the root");

  // Accumulator settled when the result is captured
  a_acc_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.q_done |-> !pend_r)
    else $error("result captured with a node read outstanding");

endmodule

`default_nettype wire
